// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, suspended while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, also evaluated while reset is held.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/rsc_pkg.sv -----
package rsc_pkg;

  localparam int WORD_W = 28;
  localparam int NIB_N  = 7;

  localparam logic       OP_DECODE    = 1'b0;
  localparam logic       OP_ENCODE    = 1'b1;
  localparam logic [5:0] BIT_COUNT_OK = 6'd28;
  localparam logic [3:0] NIB6_MASK    = 4'd9;
  localparam logic [3:0] DIM_LOW      = 4'd2;
  localparam logic [3:0] DIM_HIGH     = 4'd9;

  localparam logic [3:0] FWD_KEY [17] = '{
    4'd9, 4'd6, 4'd3, 4'd8, 4'd10, 4'd0, 4'd2, 4'd12, 4'd4,
    4'd14, 4'd7, 4'd5, 4'd1, 4'd15, 4'd11, 4'd13, 4'd9
  };

  localparam logic [3:0] INV_KEY [16] = '{
    4'd5, 4'd12, 4'd6, 4'd2, 4'd8, 4'd11, 4'd1, 4'd10,
    4'd3, 4'd0, 4'd4, 4'd14, 4'd7, 4'd15, 4'd9, 4'd13
  };

  typedef struct packed {
    logic        operation;
    logic [27:0] code_word;
    logic [5:0]  bit_count;
    logic [15:0] transmitter_id;
    logic [3:0]  receiver_id;
    logic [3:0]  command_value;
  } rsc_in_t;

  typedef struct packed {
    logic        valid_res;
    logic [27:0] encoded_word;
    logic [15:0] transmitter_id_out;
    logic [3:0]  receiver_id_out;
    logic [3:0]  decoded_value;
    logic [1:0]  rolling_code_out;
  } rsc_out_t;

  // The first round reads the key one place further along than the second.
  function automatic logic [3:0] fwd_sub(input logic [3:0] x, input logic rnd);
    logic [4:0] idx;
    idx = {1'b0, x} + {4'b0, ~rnd};
    return FWD_KEY[idx];
  endfunction

  function automatic logic [3:0] inv_sub(input logic [3:0] x, input logic rnd);
    return INV_KEY[x] - {3'b0, rnd};
  endfunction

endpackage

// ----- rtl/remote_switch_code_cipher.sv -----
// An accepted beat is held in the input register, then moves to the result register
// once that register is empty or being read; out_valid rises when it gets there.
// Throughput: one item per cycle while out_ready is high; both directions finish in
// one lookup pass. While a result waits, only an empty input register takes input.
// Reset (rst_n low, synchronous) empties both stages and clears the rolling counter.
module remote_switch_code_cipher (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rsc_pkg::rsc_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rsc_pkg::rsc_out_t out_data
);
  import rsc_pkg::*;

  logic      s1_v_r;
  rsc_in_t   s1_data_r;
  logic [1:0] s1_roll_r;
  logic [1:0] roll_cnt_r;
  logic [1:0] roll_cnt_nxt;
  logic      out_v_r;
  rsc_out_t  out_data_r;
  rsc_out_t  dec_res;
  rsc_out_t  enc_res;
  rsc_out_t  res_nxt;
  logic      adv2;
  logic      in_fire;

  assign adv2     = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || adv2;
  assign in_fire  = in_valid && in_ready;

  // The counter advances before use, so the first encode carries code one.
  assign roll_cnt_nxt = roll_cnt_r + 2'd1;

  rsc_decode u_dec (
    .code_word (s1_data_r.code_word),
    .dec_res   (dec_res)
  );

  rsc_encode u_enc (
    .transmitter_id (s1_data_r.transmitter_id),
    .receiver_id    (s1_data_r.receiver_id),
    .command_value  (s1_data_r.command_value),
    .roll_code      (s1_roll_r),
    .enc_res        (enc_res)
  );

  always_comb begin
    if (s1_data_r.operation == OP_ENCODE) begin
      res_nxt = enc_res;
    end else if (s1_data_r.bit_count == BIT_COUNT_OK) begin
      res_nxt = dec_res;
    end else begin
      res_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      roll_cnt_r <= 2'd0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (adv2) begin
        out_v_r <= s1_v_r;
      end
      if (in_fire && (in_data.operation == OP_ENCODE)) begin
        roll_cnt_r <= roll_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
      s1_roll_r <= roll_cnt_nxt;
    end
    if (adv2 && s1_v_r) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/rsc_decode.sv -----
module rsc_decode (
  input  logic [27:0]      code_word,
  output rsc_pkg::rsc_out_t dec_res
);
  import rsc_pkg::*;

  logic [27:0] rot_w;
  logic [3:0]  nb0 [NIB_N];
  logic [3:0]  nb1 [NIB_N];
  logic [3:0]  nb2 [NIB_N];
  logic [3:0]  val_sum;

  assign rot_w = {code_word[25:0], code_word[27:26]};

  // Each round chains with the neighbor's value from before that round,
  // so all nibbles of a round are independent lookups.
  always_comb begin
    for (int i = 0; i < NIB_N; i++) begin
      nb0[i] = rot_w[4*i +: 4];
    end
    nb0[6] = nb0[6] ^ NIB6_MASK;
    nb1[0] = inv_sub(nb0[0], 1'b0);
    nb2[0] = inv_sub(nb1[0], 1'b1);
    for (int i = 1; i < NIB_N - 1; i++) begin
      nb1[i] = inv_sub(nb0[i], 1'b0) ^ nb0[i-1];
    end
    for (int i = 1; i < NIB_N - 1; i++) begin
      nb2[i] = inv_sub(nb1[i], 1'b1) ^ nb1[i-1];
    end
    nb1[6] = nb0[6];
    nb2[6] = nb1[6];
  end

  assign val_sum = {3'b0, nb2[1][1]} + {1'b0, nb2[6][2:0]} + {3'b0, nb2[6][3]};

  always_comb begin
    dec_res                    = '0;
    dec_res.valid_res          = 1'b1;
    dec_res.transmitter_id_out = {nb2[5], nb2[4], nb2[3], nb2[2]};
    dec_res.receiver_id_out    = nb2[0];
    dec_res.decoded_value      = val_sum;
    dec_res.rolling_code_out   = nb2[1][3:2];
  end

endmodule

// ----- rtl/rsc_encode.sv -----
module rsc_encode (
  input  logic [15:0]       transmitter_id,
  input  logic [3:0]        receiver_id,
  input  logic [3:0]        command_value,
  input  logic [1:0]        roll_code,
  output rsc_pkg::rsc_out_t enc_res
);
  import rsc_pkg::*;

  logic [3:0]  nb [NIB_N];
  logic [3:0]  r0 [NIB_N - 1];
  logic [3:0]  r1 [NIB_N - 1];
  logic [3:0]  nib6;
  logic [27:0] word;
  logic        is_dim;

  assign is_dim = command_value inside {[DIM_LOW:DIM_HIGH]};
  assign nib6   = is_dim ? ((command_value - DIM_LOW) | 4'd8) : 4'd0;

  // Here each nibble chains with the already encrypted neighbor.
  always_comb begin
    nb[0] = receiver_id;
    nb[1] = {roll_code, (command_value != 4'd0), 1'b0};
    for (int i = 0; i < 4; i++) begin
      nb[2+i] = transmitter_id[4*i +: 4];
    end
    nb[6] = nib6;
    r0[0] = fwd_sub(nb[0], 1'b0);
    for (int i = 1; i < NIB_N - 1; i++) begin
      r0[i] = fwd_sub(nb[i] ^ r0[i-1], 1'b0);
    end
    r1[0] = fwd_sub(r0[0], 1'b1);
    for (int i = 1; i < NIB_N - 1; i++) begin
      r1[i] = fwd_sub(r0[i] ^ r1[i-1], 1'b1);
    end
  end

  assign word = {nb[6] ^ NIB6_MASK, r1[5], r1[4], r1[3], r1[2], r1[1], r1[0]};

  always_comb begin
    enc_res              = '0;
    enc_res.valid_res    = 1'b1;
    enc_res.encoded_word = {word[1:0], word[27:2]};
  end

endmodule

// ----- rtl/rsc_checker.sv -----
`include "assert_macros.svh"

module rsc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input rsc_pkg::rsc_out_t out_data
);

  logic bad_len_beat;
  logic enc_beat;
  logic dec_fields_zero;

  assign bad_len_beat    = out_valid && !out_data.valid_res;
  assign enc_beat        = out_valid && (out_data.encoded_word != 28'd0);
  assign dec_fields_zero = (out_data.transmitter_id_out == 16'd0) &&
                           (out_data.receiver_id_out == 4'd0) &&
                           (out_data.decoded_value == 4'd0) &&
                           (out_data.rolling_code_out == 2'd0);

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped")

  `ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result beat right after reset")

  `ASSERT_CLK(a_bad_len_zero, bad_len_beat |-> out_data == '0, "rejected decode carries data")

  `ASSERT_CLK(a_enc_no_dec, enc_beat |-> dec_fields_zero, "encode beat carries decode fields")

  `ASSERT_CLK(a_value_range, out_valid |-> out_data.decoded_value <= 4'd9, "decoded value too big")

endmodule

bind remote_switch_code_cipher rsc_checker u_rsc_checker (.*);
